// File: rtl/pidl_pkg.sv
`timescale 1ns / 1ps

package pidl_pkg;

    // Storage geometry.
    localparam int DEPTH      = 1024;
    localparam int WORD_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int LEN_W      = $clog2(DEPTH + 1);

    // Fixed field widths of the interface.
    localparam int OP_W    = 2;
    localparam int POS_W   = 11;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 11;
    localparam int OLEN_W  = 11;

    // Width used for all length, position and capacity compares.
    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W + 1 : POS_W + 1;

    // Capacity register reset value.
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Input word.
    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic                    success;
        logic signed [VAL_W-1:0] read_value;
        logic [OLEN_W-1:0]       list_length_out;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step_up;
        logic step_down;
        logic put;
        logic rd_pos;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  in_op;
        logic in_ok;
        logic in_move;
        logic ptr_last;
        logic out_free;
    } status_t;

endpackage

// File: rtl/pidl_ram.sv
`timescale 1ns / 1ps

module pidl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port; the read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/pidl_ctrl.sv
`timescale 1ns / 1ps

module pidl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  pidl_pkg::status_t status,
    output pidl_pkg::cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_IDLE       = 8'b0000_0001,
        S_SHIFT_UP   = 8'b0000_0010,
        S_UP_TAIL    = 8'b0000_0100,
        S_PUT        = 8'b0000_1000,
        S_SHIFT_DOWN = 8'b0001_0000,
        S_DOWN_TAIL  = 8'b0010_0000,
        S_READ       = 8'b0100_0000,
        S_FINISH     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (!status.in_ok)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        case (status.in_op)
                            pidl_pkg::OP_INSERT:
                                state_next = status.in_move ? S_SHIFT_UP : S_PUT;
                            pidl_pkg::OP_REMOVE:
                                state_next = status.in_move ? S_SHIFT_DOWN : S_FINISH;
                            pidl_pkg::OP_READ:
                                state_next = S_READ;
                            default:
                                state_next = S_FINISH;
                        endcase
                    end
                end
            end
            S_SHIFT_UP:
            begin
                cmd.step_up = 1'b1;
                if (status.ptr_last)
                begin
                    state_next = S_UP_TAIL;
                end
            end
            S_UP_TAIL:
            begin
                // The last shifted word is written back in this cycle.
                state_next = S_PUT;
            end
            S_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = S_FINISH;
            end
            S_SHIFT_DOWN:
            begin
                cmd.step_down = 1'b1;
                if (status.ptr_last)
                begin
                    state_next = S_DOWN_TAIL;
                end
            end
            S_DOWN_TAIL:
            begin
                state_next = S_FINISH;
            end
            S_READ:
            begin
                cmd.rd_pos = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/pidl_dpath.sv
`timescale 1ns / 1ps

module pidl_dpath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pidl_pkg::in_word_t               in_data,
    input  logic                             cfg_valid,
    input  logic [pidl_pkg::CAP_W-1:0]       cfg_data,
    input  logic                             out_stall,
    output logic                             out_valid,
    output pidl_pkg::out_word_t              out_data,
    input  pidl_pkg::cmd_t                   cmd,
    output pidl_pkg::status_t                status
);

    localparam int CW = pidl_pkg::CMP_W;
    localparam int LW = pidl_pkg::LEN_W;
    localparam int AW = pidl_pkg::ADDR_W;
    localparam int WW = pidl_pkg::WORD_WIDTH;

    logic [pidl_pkg::CAP_W-1:0] cap_reg;
    logic [LW-1:0]              len_reg;
    logic [LW-1:0]              len_next;
    pidl_pkg::op_t              op_reg;
    logic [pidl_pkg::POS_W-1:0] pos_reg;
    logic [WW-1:0]              word_reg;
    logic                       ok_reg;
    logic [LW-1:0]              ptr_reg;
    logic                       wb_valid_reg;
    logic [LW-1:0]              wb_addr_reg;
    logic                       out_valid_reg;
    pidl_pkg::out_word_t        out_data_reg;

    logic [CW-1:0] len_c;
    logic [CW-1:0] pos_c;
    logic [CW-1:0] cap_c;
    logic [CW-1:0] depth_c;
    logic          ins_ok;
    logic          pos_in_list;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [WW-1:0] ram_rdata;

    // Checks on the incoming word against the current length and capacity.
    assign len_c       = CW'(len_reg);
    assign pos_c       = CW'(in_data.position);
    assign cap_c       = CW'(cap_reg);
    assign depth_c     = CW'(pidl_pkg::DEPTH);
    assign ins_ok      = (pos_c <= len_c) && (len_c < cap_c) && (len_c < depth_c);
    assign pos_in_list = (pos_c < len_c);

    always_comb
    begin
        // Shift ends at the target position going up, at the list tail going down.
        status.ptr_last = (op_reg == pidl_pkg::OP_INSERT)
                        ? (CW'(ptr_reg) == CW'(pos_reg))
                        : (CW'(ptr_reg) + CW'(1) == len_c);
        status.out_free = !out_valid_reg || !out_stall;
        status.in_op    = pidl_pkg::op_t'(in_data.operation);
        case (pidl_pkg::op_t'(in_data.operation))
            pidl_pkg::OP_INSERT:
            begin
                status.in_ok   = ins_ok;
                status.in_move = (pos_c < len_c);
            end
            pidl_pkg::OP_REMOVE:
            begin
                status.in_ok   = pos_in_list;
                status.in_move = ((pos_c + CW'(1)) < len_c);
            end
            pidl_pkg::OP_READ:
            begin
                status.in_ok   = pos_in_list;
                status.in_move = 1'b0;
            end
            default:
            begin
                status.in_ok   = 1'b0;
                status.in_move = 1'b0;
            end
        endcase
    end

    // Capacity register; the port is always ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= pidl_pkg::CAP_RESET;
        end
        else if (cfg_valid)
        begin
            cap_reg <= cfg_data;
        end
    end

    // Item capture and shift pointer.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= pidl_pkg::op_t'(in_data.operation);
            pos_reg  <= in_data.position;
            word_reg <= WW'(in_data.value);
            ok_reg   <= status.in_ok;
            if (pidl_pkg::op_t'(in_data.operation) == pidl_pkg::OP_INSERT)
            begin
                ptr_reg <= len_reg - LW'(1);
            end
            else
            begin
                ptr_reg <= LW'(in_data.position) + LW'(1);
            end
        end
        else if (cmd.step_up)
        begin
            ptr_reg <= ptr_reg - LW'(1);
        end
        else if (cmd.step_down)
        begin
            ptr_reg <= ptr_reg + LW'(1);
        end
    end

    // A word read during a shift step is written one place over in the next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= cmd.step_up || cmd.step_down;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step_up)
        begin
            wb_addr_reg <= ptr_reg + LW'(1);
        end
        else if (cmd.step_down)
        begin
            wb_addr_reg <= ptr_reg - LW'(1);
        end
    end

    // Memory port selection.
    assign ram_re    = cmd.step_up || cmd.step_down || cmd.rd_pos;
    assign ram_raddr = cmd.rd_pos ? pos_reg[AW-1:0] : ptr_reg[AW-1:0];
    assign ram_we    = wb_valid_reg || cmd.put;
    assign ram_waddr = cmd.put ? pos_reg[AW-1:0] : wb_addr_reg[AW-1:0];
    assign ram_wdata = cmd.put ? word_reg : ram_rdata;

    pidl_ram #(
        .WIDTH (WW),
        .DEPTH (pidl_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Length after the operation.
    always_comb
    begin
        len_next = len_reg;
        if (ok_reg && (op_reg == pidl_pkg::OP_INSERT))
        begin
            len_next = len_reg + LW'(1);
        end
        else if (ok_reg && (op_reg == pidl_pkg::OP_REMOVE))
        begin
            len_next = len_reg - LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cmd.finish)
        begin
            len_reg <= len_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg.success         <= ok_reg;
            out_data_reg.list_length_out <= pidl_pkg::OLEN_W'(len_next);
            if (ok_reg && (op_reg == pidl_pkg::OP_READ))
            begin
                out_data_reg.read_value <= pidl_pkg::VAL_W'(signed'(ram_rdata));
            end
            else
            begin
                out_data_reg.read_value <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/positional_insert_delete_list.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake            | Data
// ---------+-----------+----------------------+-------------------------------
// in       | input     | in_valid / in_stall  | in_data  (operation, position, value)
// out      | output    | out_valid / out_stall| out_data (success, read_value, length)
// cfg      | input     | cfg_valid / cfg_ready| cfg_data (capacity_limit)
//
// One word at a time. Insert moves the entries from the tail down to the position
// one place up and then writes the new entry; remove moves the entries above the
// position one place down; read fetches the entry; a failed check or an unused
// code goes straight to the result. The shift runs through the entry memory, one entry per cycle.
// Reset clears the length and sets the capacity to 1024; entries need no clearing.
// A stalled result holds in the output register; the next word is taken meanwhile.

module positional_insert_delete_list (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  pidl_pkg::in_word_t         in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output pidl_pkg::out_word_t        out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pidl_pkg::CAP_W-1:0] cfg_data
);

    pidl_pkg::cmd_t    cmd;
    pidl_pkg::status_t status;

    assign cfg_ready = 1'b1;

    pidl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pidl_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
